// ----- hw/rtl/sfr_pkg.sv -----
// ----------------------------------------------------------------------------
// sfr_pkg
// Shared types and constants for the sum-checked frame receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package sfr_pkg;

  localparam int BYTE_W            = 8;
  localparam int POS_OUT_W         = 5;
  localparam int MAX_FRAME_LEN_DEF = 24;

  localparam logic [BYTE_W-1:0] FRAME_HEADER = 8'h68;

  typedef enum logic [1:0] {
    ST_BUSY = 2'd0,
    ST_GOOD = 2'd1,
    ST_BAD  = 2'd2
  } status_t;

  // frame state apart from the position counter
  typedef struct packed {
    logic [BYTE_W-1:0] len;
    logic              len_known;
    logic [BYTE_W-1:0] sum;
  } sfr_state_t;

endpackage

`default_nettype wire

// ----- hw/rtl/sfr_if.sv -----
// ----------------------------------------------------------------------------
// sfr channels
// Valid/ready channels for received bytes, per-byte results and the
// device address write port.
// ----------------------------------------------------------------------------
`default_nettype none

interface sfr_in_if;
  import sfr_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sfr_out_if;
  import sfr_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [1:0]           status;
  logic [POS_OUT_W-1:0] position;
  logic [BYTE_W-1:0]    byte_out;
  modport source (output valid, output status, output position, output byte_out,
                  input ready);
  modport sink   (input valid, input status, input position, input byte_out,
                  output ready);
endinterface

interface sfr_cfg_if;
  import sfr_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] device_address;
  modport source (output valid, output device_address, input ready);
  modport sink   (input valid, input device_address, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/sfr_decoder.sv -----
// ----------------------------------------------------------------------------
// sfr_decoder
// Per-byte frame check: header, length, address and checksum, giving the
// byte's status and the next frame state.
// ----------------------------------------------------------------------------
`default_nettype none

module sfr_decoder #(
  parameter int MAX_FRAME_LEN = sfr_pkg::MAX_FRAME_LEN_DEF,
  parameter int POS_W         = $clog2(MAX_FRAME_LEN + 1)
) (
  input  wire logic [POS_W-1:0]          pos,
  input  wire sfr_pkg::sfr_state_t       state,
  input  wire logic [sfr_pkg::BYTE_W-1:0] rx_byte,
  input  wire logic [sfr_pkg::BYTE_W-1:0] device_address,
  output sfr_pkg::status_t               status,
  output logic [POS_W-1:0]               pos_nxt,
  output sfr_pkg::sfr_state_t            state_nxt
);
  import sfr_pkg::*;

  localparam logic [BYTE_W-1:0] MAX_LEN = BYTE_W'(MAX_FRAME_LEN);

  logic              done;
  logic [BYTE_W-1:0] len_c;
  logic              known_c;
  logic [BYTE_W-1:0] pos_ext;

  assign pos_ext = BYTE_W'(pos);

  always_comb begin
    done    = 1'b0;
    status  = ST_BUSY;
    len_c   = state.len;
    known_c = state.len_known;

    if (pos == '0) begin
      if (rx_byte != FRAME_HEADER) begin
        status = ST_BAD;
        done   = 1'b1;
      end
    end else begin
      if (pos == POS_W'(1)) begin
        if (rx_byte == '0 || rx_byte > MAX_LEN) begin
          status = ST_BAD;
          done   = 1'b1;
        end else begin
          len_c   = rx_byte;
          known_c = 1'b1;
        end
      end else if (pos == POS_W'(2) && rx_byte != device_address) begin
        status = ST_BAD;
        done   = 1'b1;
      end
      // checksum byte at the end of the frame
      if (!done && (!known_c || pos_ext >= len_c)) begin
        status = (known_c && rx_byte == state.sum) ? ST_GOOD : ST_BAD;
        done   = 1'b1;
      end
    end

    if (done) begin
      pos_nxt   = '0;
      state_nxt = '0;
    end else begin
      pos_nxt             = POS_W'(pos + 1'b1);
      state_nxt.len       = len_c;
      state_nxt.len_known = known_c;
      state_nxt.sum       = (pos != '0) ? BYTE_W'(state.sum + rx_byte) : state.sum;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/sum_checked_frame_receiver.sv -----
// ----------------------------------------------------------------------------
// sum_checked_frame_receiver
// Tracks length-prefixed frames in a stream of received bytes and reports a
// status, position and the byte itself for every beat.
// ----------------------------------------------------------------------------
// each accepted byte's result beat is registered and shows up in the cycle after the byte is accepted
// throughput: one byte per cycle while result beats are taken, set by the registered frame state update
// the result register frees the input whenever its beat is taken or empty
// reset: frame state, device address and result valid clear to zero
`default_nettype none

module sum_checked_frame_receiver #(
  parameter int MAX_FRAME_LEN = sfr_pkg::MAX_FRAME_LEN_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  sfr_in_if.sink     in_ch,
  sfr_out_if.source  out_ch,
  sfr_cfg_if.sink    cfg_ch
);
  import sfr_pkg::*;

  localparam int POS_W = $clog2(MAX_FRAME_LEN + 1);

  logic [POS_W-1:0]     pos_r, pos_nxt;
  sfr_state_t           state_r, state_nxt;
  logic [BYTE_W-1:0]    addr_r;
  logic                 out_valid_r;
  status_t              out_status_r;
  logic [POS_OUT_W-1:0] out_pos_r;
  logic [BYTE_W-1:0]    out_byte_r;
  status_t              status_c;
  logic                 in_fire;

  sfr_decoder #(
    .MAX_FRAME_LEN (MAX_FRAME_LEN),
    .POS_W         (POS_W)
  ) u_decoder (
    .pos            (pos_r),
    .state          (state_r),
    .rx_byte        (in_ch.rx_byte),
    .device_address (addr_r),
    .status         (status_c),
    .pos_nxt        (pos_nxt),
    .state_nxt      (state_nxt)
  );

  assign in_ch.ready  = !out_valid_r || out_ch.ready;
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  assign out_ch.valid    = out_valid_r;
  assign out_ch.status   = out_status_r;
  assign out_ch.position = out_pos_r;
  assign out_ch.byte_out = out_byte_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      state_r     <= '0;
      addr_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_ch.valid) begin
        addr_r <= cfg_ch.device_address;
      end
      if (in_fire) begin
        pos_r       <= pos_nxt;
        state_r     <= state_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_status_r <= status_c;
      out_pos_r    <= POS_OUT_W'(pos_r);
      out_byte_r   <= in_ch.rx_byte;
    end
  end

  a_end_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && status_c != ST_BUSY |=> pos_r == '0 && state_r == '0)
    else $error("frame end or reject did not restart the receiver");

  a_busy_advances: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && status_c == ST_BUSY |=> pos_r == POS_W'($past(pos_r) + 1'b1))
    else $error("in-progress beat did not advance position");

  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    BYTE_W'(pos_r) <= BYTE_W'(MAX_FRAME_LEN))
    else $error("frame position beyond maximum frame length");

  a_header_seen: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && pos_r == '0 && status_c == ST_BUSY |-> in_ch.rx_byte == FRAME_HEADER)
    else $error("frame started without header byte");

  a_len_known: assert property (@(posedge clk) disable iff (!rst_n)
    BYTE_W'(pos_r) >= BYTE_W'(2) |-> state_r.len_known && state_r.len != '0)
    else $error("frame past length byte without a known length");

endmodule

`default_nettype wire
